// ===== hdl/pwdg_pkg.sv =====
// ----------------------------------------------------------------------------
// pwdg_pkg
// Shared widths, register indexes and stream layout for the wait/detour gate.
// ----------------------------------------------------------------------------
package pwdg_pkg;

  localparam int MAX_IDS = 16;
  localparam int IDX_W   = $clog2(MAX_IDS);
  localparam int CNT_W   = $clog2(MAX_IDS + 1);
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int TICK_W  = 16;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_GATE_ENABLE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLEAR_TICKS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WAIT_TICKS  = 2'd2;

  localparam logic [TICK_W-1:0] CLEAR_TICKS_RST = 16'd1000;
  localparam logic [TICK_W-1:0] WAIT_TICKS_RST  = 16'd5000;

  // item kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_EVAL   = 1'b1;

  // modes
  localparam logic [1:0] MODE_FOLLOW = 2'd0;
  localparam logic [1:0] MODE_WAIT   = 2'd1;
  localparam logic [1:0] MODE_DETOUR = 2'd2;

  // reason codes
  localparam logic [2:0] RSN_DISABLED      = 3'd0;
  localparam logic [2:0] RSN_CORRIDOR_CLR  = 3'd1;
  localparam logic [2:0] RSN_CLEAR_HOLD    = 3'd2;
  localparam logic [2:0] RSN_ON_PATH       = 3'd3;
  localparam logic [2:0] RSN_ID_CLEAR_HOLD = 3'd4;
  localparam logic [2:0] RSN_TIMEOUT       = 3'd5;
  localparam logic [2:0] RSN_LATCHED       = 3'd6;

  // stream widths
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 64;

endpackage

// ===== hdl/pwdg_span.sv =====
// ----------------------------------------------------------------------------
// pwdg_span
// Shared time unit: wrapped duration now - start and its compare to a limit.
// ----------------------------------------------------------------------------
module pwdg_span (
  input  logic [pwdg_pkg::TIME_W-1:0] now,
  input  logic [pwdg_pkg::TIME_W-1:0] start,
  input  logic [pwdg_pkg::TICK_W-1:0] limit,
  output logic [pwdg_pkg::TIME_W-1:0] span,
  output logic                        reach
);

  // modulo subtract, then compare against the zero-extended limit
  assign span  = now - start;
  assign reach = span >= {{(pwdg_pkg::TIME_W - pwdg_pkg::TICK_W){1'b0}}, limit};

endmodule

// ===== hdl/per_id_wait_detour_gate.sv =====
// ----------------------------------------------------------------------------
// per_id_wait_detour_gate
// Gathers blocking obstacle ids and, on evaluate, tracks per-id wait and
// absence times to choose follow, wait or detour mode.
// ----------------------------------------------------------------------------
// An id report (tuser 0) is taken and the block stays ready. An evaluate
// item (tuser 1) walks the 16-entry tables through one shared time
// subtract/compare unit: a match-and-prune sweep, an allocation sweep, a
// latch sweep (or a single corridor-clear step when nothing blocks) and a
// counting sweep. A final step hands the result to the output register.
// A disabled gate skips the sweeps and goes straight to the output step.
// The output step waits while an earlier result beat is still held and
// not taken. Input is not taken during an evaluation, including that wait;
// a result beat already held on the master side does not by itself hold
// back the next input item.
module per_id_wait_detour_gate (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [pwdg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pwdg_pkg::TICK_W-1:0]       cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pwdg_pkg::S_DATA_W-1:0]     s_tdata,  // obstacle_id, now_ticks, list valid flag
  input  logic [0:0]                        s_tuser,  // kind
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pwdg_pkg::M_DATA_W-1:0]     m_tdata   // mode, prior mode, reason,
                                                      // elapsed_wait, remaining_wait,
                                                      // blocking_count, waiting_count,
                                                      // latched_count,
                                                      // unlatched_blocking_count,
                                                      // table_overflow
);

  localparam int N  = pwdg_pkg::MAX_IDS;
  localparam int IW = pwdg_pkg::IDX_W;
  localparam int CW = pwdg_pkg::CNT_W;
  localparam int DW = pwdg_pkg::ID_W;
  localparam int TW = pwdg_pkg::TIME_W;
  localparam int KW = pwdg_pkg::TICK_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ALLOC, S_LATCH, S_CLR, S_COUNT, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic          gate_enable;
  logic [KW-1:0] clear_ticks;
  logic [KW-1:0] wait_ticks;

  // gathered blocking set
  logic [DW-1:0] set_id [N];
  logic [N-1:0]  used;
  logic [N-1:0]  blv;

  // track table
  logic [DW-1:0] track_id     [N];
  logic [TW-1:0] wait_start   [N];
  logic [TW-1:0] absent_start [N];
  logic [N-1:0]  fw, fl, fa;
  logic [N-1:0]  inbl;
  logic [N-1:0]  found;
  logic [IW-1:0] trk_of [N];

  // control and accumulators
  logic [IW-1:0] idx;
  logic [TW-1:0] now_r;
  logic [1:0]    current_mode;
  logic [1:0]    prev_mode;
  logic          clear_armed;
  logic [TW-1:0] clear_start;
  logic          overflow_seen;
  logic          blk_br;
  logic [2:0]    reason_r;
  logic          latch_hit;
  logic          on_path;
  logic [CW-1:0] nbl, waitc, latc, unlc;
  logic [KW-1:0] max_el, min_rem;

  // combinational helpers
  logic [DW-1:0] rpt_id;
  logic          rpt_dup;
  logic          rpt_has_free;
  logic [IW-1:0] rpt_free;
  logic [N-1:0]  trk_valid;
  logic          trk_has_free;
  logic [IW-1:0] trk_free;
  logic [N-1:0]  hit_vec;
  logic          idx_last;
  logic [TW-1:0] span_start;
  logic [KW-1:0] span_limit;
  logic [TW-1:0] span;
  logic          reach;
  logic [IW-1:0] kj;
  logic          out_free;
  logic [1:0]    mode_o;
  logic [2:0]    reason_o;
  logic [KW-1:0] el_o, rem_o;
  logic [CW-1:0] waitc_o;

  assign rpt_id    = s_tdata[DW-1:0];
  assign trk_valid = fw | fl | fa;
  assign idx_last  = idx == IW'(N - 1);
  assign kj        = trk_of[idx];
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = state == S_IDLE;

  // report lookup: duplicate check and first free set slot
  always_comb begin
    rpt_dup      = 1'b0;
    rpt_has_free = 1'b0;
    rpt_free     = '0;
    for (int j = N - 1; j >= 0; j--) begin
      if (used[j] && set_id[j] == rpt_id) rpt_dup = 1'b1;
      if (!used[j]) begin
        rpt_has_free = 1'b1;
        rpt_free     = IW'(j);
      end
    end
  end

  // first free track entry
  always_comb begin
    trk_has_free = 1'b0;
    trk_free     = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!trk_valid[i]) begin
        trk_has_free = 1'b1;
        trk_free     = IW'(i);
      end
    end
  end

  // blocking ids that match the track entry under the sweep
  always_comb begin
    for (int j = 0; j < N; j++) begin
      hit_vec[j] = blv[j] && set_id[j] == track_id[idx];
    end
  end

  // operand select for the shared time unit
  always_comb begin
    unique case (state)
      S_SCAN: begin
        span_start = fa[idx] ? absent_start[idx] : now_r;
        span_limit = clear_ticks;
      end
      S_LATCH: begin
        span_start = wait_start[kj];
        span_limit = wait_ticks;
      end
      S_CLR: begin
        span_start = clear_armed ? clear_start : now_r;
        span_limit = clear_ticks;
      end
      default: begin
        span_start = wait_start[idx];
        span_limit = wait_ticks;
      end
    endcase
  end

  pwdg_span u_span (
    .now   (now_r),
    .start (span_start),
    .limit (span_limit),
    .span  (span),
    .reach (reach)
  );

  // result fields
  always_comb begin
    mode_o   = current_mode;
    reason_o = reason_r;
    el_o     = '0;
    rem_o    = '1;
    waitc_o  = '0;
    if (blk_br) begin
      waitc_o = waitc;
      if (waitc != '0) begin
        mode_o   = pwdg_pkg::MODE_WAIT;
        reason_o = on_path ? pwdg_pkg::RSN_ON_PATH : pwdg_pkg::RSN_ID_CLEAR_HOLD;
        el_o     = max_el;
        rem_o    = min_rem;
      end else begin
        mode_o   = pwdg_pkg::MODE_DETOUR;
        reason_o = latch_hit ? pwdg_pkg::RSN_TIMEOUT : pwdg_pkg::RSN_LATCHED;
      end
    end
  end

  // sequencer, tables and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      gate_enable   <= 1'b1;
      clear_ticks   <= pwdg_pkg::CLEAR_TICKS_RST;
      wait_ticks    <= pwdg_pkg::WAIT_TICKS_RST;
      used          <= '0;
      fw            <= '0;
      fl            <= '0;
      fa            <= '0;
      current_mode  <= pwdg_pkg::MODE_FOLLOW;
      clear_armed   <= 1'b0;
      clear_start   <= '0;
      overflow_seen <= 1'b0;
      m_tvalid      <= 1'b0;
      idx           <= '0;
    end else begin
      // output valid: loaded by the final step, dropped once taken
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // register writes
      if (cfg_we) begin
        unique case (cfg_addr)
          pwdg_pkg::REG_GATE_ENABLE: gate_enable <= cfg_data[0];
          pwdg_pkg::REG_CLEAR_TICKS: clear_ticks <= cfg_data;
          pwdg_pkg::REG_WAIT_TICKS:  wait_ticks  <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser[0] == pwdg_pkg::KIND_REPORT) begin
              if (!rpt_dup) begin
                if (rpt_has_free) begin
                  set_id[rpt_free] <= rpt_id;
                  used[rpt_free]   <= 1'b1;
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
            end else begin
              now_r       <= s_tdata[DW+TW-1:DW];
              blv         <= used & {N{s_tdata[DW+TW]}};
              used        <= '0;
              prev_mode   <= current_mode;
              found       <= '0;
              inbl        <= '0;
              nbl         <= '0;
              waitc       <= '0;
              latc        <= '0;
              unlc        <= '0;
              max_el      <= '0;
              min_rem     <= '1;
              latch_hit   <= 1'b0;
              on_path     <= 1'b0;
              blk_br      <= 1'b0;
              idx         <= '0;
              if (!gate_enable) begin
                current_mode <= pwdg_pkg::MODE_FOLLOW;
                fw           <= '0;
                fl           <= '0;
                fa           <= '0;
                clear_armed  <= 1'b0;
                reason_r     <= pwdg_pkg::RSN_DISABLED;
                state        <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end

        // match tracked ids against the set, mark absence, prune
        S_SCAN: begin
          if (trk_valid[idx]) begin
            inbl[idx] <= |hit_vec;
            for (int j = 0; j < N; j++) begin
              if (hit_vec[j]) begin
                found[j]  <= 1'b1;
                trk_of[j] <= idx;
              end
            end
            if (|hit_vec) begin
              fa[idx] <= 1'b0;
            end else if (reach) begin
              fw[idx] <= 1'b0;
              fl[idx] <= 1'b0;
              fa[idx] <= 1'b0;
            end else begin
              if (!fa[idx]) absent_start[idx] <= now_r;
              fa[idx] <= 1'b1;
            end
          end
          idx <= idx + 1'b1;
          if (idx_last) state <= S_ALLOC;
        end

        // new wait entries for untracked blocking ids
        S_ALLOC: begin
          if (blv[idx]) begin
            nbl <= nbl + 1'b1;
            if (!found[idx]) begin
              if (trk_has_free) begin
                track_id[trk_free]   <= set_id[idx];
                wait_start[trk_free] <= now_r;
                fw[trk_free]         <= 1'b1;
                inbl[trk_free]       <= 1'b1;
                trk_of[idx]          <= trk_free;
                found[idx]           <= 1'b1;
              end else begin
                overflow_seen <= 1'b1;
              end
            end
          end
          idx <= idx + 1'b1;
          if (idx_last) begin
            state <= (nbl == '0 && !blv[idx]) ? S_CLR : S_LATCH;
          end
        end

        // nothing blocks: corridor clear timer
        S_CLR: begin
          clear_armed <= 1'b1;
          if (!clear_armed) clear_start <= now_r;
          if (reach) begin
            current_mode <= pwdg_pkg::MODE_FOLLOW;
            fw           <= '0;
            fl           <= '0;
            fa           <= '0;
            reason_r     <= pwdg_pkg::RSN_CORRIDOR_CLR;
          end else begin
            reason_r <= pwdg_pkg::RSN_CLEAR_HOLD;
          end
          state <= S_COUNT;
        end

        // latch blocking ids whose wait ran out
        S_LATCH: begin
          clear_armed <= 1'b0;
          blk_br      <= 1'b1;
          if (blv[idx]) begin
            if (found[idx]) begin
              if (!fl[kj]) begin
                if (reach) begin
                  fw[kj]    <= 1'b0;
                  fl[kj]    <= 1'b1;
                  latch_hit <= 1'b1;
                end else begin
                  unlc <= unlc + 1'b1;
                end
              end
            end else begin
              unlc <= unlc + 1'b1;
              if (wait_ticks == '0) overflow_seen <= 1'b1;
            end
          end
          idx <= idx + 1'b1;
          if (idx_last) state <= S_COUNT;
        end

        // waiting and latched counts, extreme wait times
        S_COUNT: begin
          if (fl[idx]) latc <= latc + 1'b1;
          if (fw[idx] && !fl[idx] && !reach) begin
            waitc <= waitc + 1'b1;
            if (span[KW-1:0] > max_el) max_el <= span[KW-1:0];
            if (wait_ticks - span[KW-1:0] < min_rem) min_rem <= wait_ticks - span[KW-1:0];
            if (inbl[idx]) on_path <= 1'b1;
          end
          idx <= idx + 1'b1;
          if (idx_last) state <= S_DONE;
        end

        // hand the beat to the output register
        S_DONE: begin
          if (out_free) begin
            m_tdata       <= {4'b0, overflow_seen, unlc, latc, waitc_o, nbl,
                              rem_o, el_o, reason_o, prev_mode, mode_o};
            current_mode  <= mode_o;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // an entry is never both waiting and latched
  a_wait_latch_excl: assert property (@(posedge clk) disable iff (rst)
    (fw & fl) == '0)
    else $error("track entry both waiting and latched");

  // a new result beat only comes out of the final step
  a_beat_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result beat outside final step");

  // the overflow mark is consumed by the delivered beat
  a_ovf_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> !overflow_seen)
    else $error("overflow mark not cleared");

  // counts stay within the table size
  a_counts_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> (waitc <= CW'(N) && latc <= CW'(N) && nbl <= CW'(N)))
    else $error("count beyond table size");

endmodule
